/* hw/rtl/tgi_pkg.sv */
// shared constants and types for the trilinear grid interpolator
// grid geometry, table sizes, opcodes, register indexes, store request struct
// no dependencies
package tgi_pkg;

  // grid geometry
  localparam int NX = 32;
  localparam int NY = 32;
  localparam int NZ = 32;
  localparam int NMAX = (NX > NY) ? ((NX > NZ) ? NX : NZ) : ((NY > NZ) ? NY : NZ);
  localparam int CELL_W = $clog2(NMAX);

  // table sizes
  localparam int VALUE_DEPTH = 16384;
  localparam int IDX_AW = 15;
  localparam int IDX_DEPTH = 1 << IDX_AW;
  localparam int VAL_AW = $clog2(VALUE_DEPTH);
  localparam int ENTRY_W = 14;
  localparam int WORD_W = 32;
  localparam int WGT_W = 16;

  // corner strides, wrapped to the index address width
  localparam logic [IDX_AW-1:0] STRIDE_X = IDX_AW'(NY * NZ);
  localparam logic [IDX_AW-1:0] STRIDE_Y = IDX_AW'(NZ);

  // opcodes
  localparam logic [1:0] OP_WR_INDEX = 2'd0;
  localparam logic [1:0] OP_WR_VALUE = 2'd1;
  localparam logic [1:0] OP_POINT    = 2'd2;

  // register indexes
  localparam logic [2:0] REG_X_ORIGIN = 3'd0;
  localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
  localparam logic [2:0] REG_Z_ORIGIN = 3'd2;
  localparam logic [2:0] REG_X_SCALE  = 3'd3;
  localparam logic [2:0] REG_Y_SCALE  = 3'd4;
  localparam logic [2:0] REG_Z_SCALE  = 3'd5;

  // access request to the index and value stores
  typedef struct packed {
    logic               idx_we;
    logic [IDX_AW-1:0]  idx_addr;
    logic [ENTRY_W-1:0] idx_wdata;
    logic               val_we;
    logic [VAL_AW-1:0]  val_addr;
    logic [WORD_W-1:0]  val_wdata;
  } store_req_t;

endpackage

/* hw/rtl/tgi_mul.sv */
// shared signed multiplier with registered product
// used for axis scaling and for every lerp; depends on nothing
module tgi_mul (
  input  logic               clk_i,
  input  logic signed [32:0] a_i,
  input  logic signed [32:0] b_i,
  output logic signed [65:0] p_o
);

  logic signed [65:0] p_q;

  // product register
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

/* hw/rtl/tgi_store.sv */
// index table and value table, single port each, registered read data
// depends on tgi_pkg
module tgi_store (
  input  logic                       clk_i,
  input  tgi_pkg::store_req_t        req_i,
  output logic [tgi_pkg::ENTRY_W-1:0] idx_rdata_o,
  output logic [tgi_pkg::WORD_W-1:0]  val_rdata_o
);

  logic [tgi_pkg::ENTRY_W-1:0] idx_mem [tgi_pkg::IDX_DEPTH];
  logic [tgi_pkg::WORD_W-1:0]  val_mem [tgi_pkg::VALUE_DEPTH];
  logic [tgi_pkg::ENTRY_W-1:0] idx_rdata_q;
  logic [tgi_pkg::WORD_W-1:0]  val_rdata_q;

  // index table port
  always_ff @(posedge clk_i) begin
    if (req_i.idx_we) begin
      idx_mem[req_i.idx_addr] <= req_i.idx_wdata;
    end
    idx_rdata_q <= idx_mem[req_i.idx_addr];
  end

  // value table port
  always_ff @(posedge clk_i) begin
    if (req_i.val_we) begin
      val_mem[req_i.val_addr] <= req_i.val_wdata;
    end
    val_rdata_q <= val_mem[req_i.val_addr];
  end

  assign idx_rdata_o = idx_rdata_q;
  assign val_rdata_o = val_rdata_q;

endmodule

/* hw/rtl/trilinear_grid_interpolator_unit.sv */
// Trilinear interpolator over a 32x32x32 grid held as an index table and a value
// table. Table write items are handled without leaving idle. A point item locates its
// cell on the one shared multiplier, with a multiply state and a check state per
// axis, forms the cell address, on a cache miss fetches the eight corners through
// the single-port index and value tables, and then does the seven lerps on the
// same multiplier before its result waits to be taken. An out-of-bounds point
// returns after its failing axis check. No item is taken while a point is in work
// or its result waits. Depends on tgi_pkg, tgi_mul, tgi_store.
module trilinear_grid_interpolator_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // items in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic signed [31:0] x_coord_i,
  input  logic signed [31:0] y_coord_i,
  input  logic signed [31:0] z_coord_i,
  input  logic [14:0] table_address_i,
  input  logic [13:0] compressed_entry_i,
  input  logic signed [31:0] sample_word_i,
  // results out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [31:0] interpolated_o,
  output logic        out_of_bounds_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LMUL  = 3'd1;
  localparam logic [2:0] S_LCHK  = 3'd2;
  localparam logic [2:0] S_FLAT  = 3'd3;
  localparam logic [2:0] S_FETCH = 3'd4;
  localparam logic [2:0] S_IMUL  = 3'd5;
  localparam logic [2:0] S_IADD  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [3:0] FETCH_LAST = 4'd9;
  localparam logic [2:0] STEP_LAST  = 3'd6;

  logic [2:0]  state_q, state_d;
  logic [1:0]  ax_q, ax_d;
  logic [3:0]  fc_q, fc_d;
  logic [2:0]  step_q, step_d;

  logic [31:0] origin_q [3];
  logic [31:0] scale_q [3];
  logic [31:0] coord_q [3];
  logic [tgi_pkg::CELL_W-1:0] cell_q [3];
  logic [tgi_pkg::WGT_W-1:0]  wgt_q [3];

  logic [tgi_pkg::IDX_AW-1:0] flat_q;
  logic [tgi_pkg::IDX_AW-1:0] cached_cell_q;
  logic        cache_valid_q;
  logic [31:0] corner_q [8];
  logic [31:0] lr_q [6];
  logic        slot_ok_q;

  logic [31:0] result_q;
  logic        oob_q;

  logic        in_fire;
  logic        out_fire;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  tgi_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // tables
  tgi_pkg::store_req_t         store_req;
  logic [tgi_pkg::ENTRY_W-1:0] idx_rdata;
  logic [31:0]                 val_rdata;

  tgi_store u_store (
    .clk_i       (clk_i),
    .req_i       (store_req),
    .idx_rdata_o (idx_rdata),
    .val_rdata_o (val_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_fire    = out_valid_o && out_ready_i;
  assign interpolated_o  = result_q;
  assign out_of_bounds_o = oob_q;

  // axis offset from origin
  logic signed [32:0] axis_off;
  logic [31:0]        n_m2;
  logic [31:0]        ax_scale;
  always_comb begin
    axis_off = signed'({coord_q[ax_q][31], coord_q[ax_q]})
             - signed'({origin_q[ax_q][31], origin_q[ax_q]});
    ax_scale = scale_q[ax_q];
    case (ax_q)
      2'd0:    n_m2 = 32'(tgi_pkg::NX - 2);
      2'd1:    n_m2 = 32'(tgi_pkg::NY - 2);
      default: n_m2 = 32'(tgi_pkg::NZ - 2);
    endcase
  end

  // axis check on the registered product
  logic axis_zero, axis_oob;
  assign axis_zero = (ax_scale == 32'd0);
  assign axis_oob  = !axis_zero && (axis_off[32] || (mul_p[63:32] > n_m2));

  // flat cell address, wrapped
  logic [tgi_pkg::IDX_AW-1:0] flat;
  assign flat = tgi_pkg::IDX_AW'(cell_q[0] * tgi_pkg::STRIDE_X)
              + tgi_pkg::IDX_AW'(cell_q[1] * tgi_pkg::STRIDE_Y)
              + tgi_pkg::IDX_AW'(cell_q[2]);

  // corner address for the index read
  logic [tgi_pkg::IDX_AW-1:0] corner_addr;
  always_comb begin
    corner_addr = flat_q;
    if (fc_q[0]) corner_addr = corner_addr + tgi_pkg::IDX_AW'(1);
    if (fc_q[1]) corner_addr = corner_addr + tgi_pkg::STRIDE_Y;
    if (fc_q[2]) corner_addr = corner_addr + tgi_pkg::STRIDE_X;
  end

  // lerp operands by step
  logic [31:0] la, lb;
  logic [tgi_pkg::WGT_W-1:0] lw;
  always_comb begin
    case (step_q)
      3'd0:    begin la = corner_q[0]; lb = corner_q[4]; end
      3'd1:    begin la = corner_q[1]; lb = corner_q[5]; end
      3'd2:    begin la = corner_q[2]; lb = corner_q[6]; end
      3'd3:    begin la = corner_q[3]; lb = corner_q[7]; end
      3'd4:    begin la = lr_q[0];     lb = lr_q[2];     end
      3'd5:    begin la = lr_q[1];     lb = lr_q[3];     end
      default: begin la = lr_q[4];     lb = lr_q[5];     end
    endcase
    if (step_q < 3'd4)      lw = wgt_q[0];
    else if (step_q < 3'd6) lw = wgt_q[1];
    else                    lw = wgt_q[2];
  end

  logic [31:0] lerp_r;
  assign lerp_r = la + 32'(mul_p[47:16]);

  // multiplier operand select
  always_comb begin
    if (state_q == S_IMUL) begin
      mul_a = signed'({lb[31], lb}) - signed'({la[31], la});
      mul_b = signed'({17'd0, lw});
    end else begin
      mul_a = signed'({1'b0, axis_off[31:0]});
      mul_b = signed'({1'b0, ax_scale});
    end
  end

  // store requests
  always_comb begin
    store_req = '0;
    if (state_q == S_FETCH) begin
      store_req.idx_addr = corner_addr;
      store_req.val_addr = tgi_pkg::VAL_AW'(idx_rdata);
    end else begin
      store_req.idx_addr  = table_address_i;
      store_req.idx_wdata = compressed_entry_i;
      store_req.idx_we    = in_fire && (opcode_i == tgi_pkg::OP_WR_INDEX);
      store_req.val_addr  = tgi_pkg::VAL_AW'(table_address_i);
      store_req.val_wdata = sample_word_i;
      store_req.val_we    = in_fire && (opcode_i == tgi_pkg::OP_WR_VALUE)
                          && (32'(table_address_i) < 32'(tgi_pkg::VALUE_DEPTH));
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    fc_d    = fc_q;
    step_d  = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && opcode_i == tgi_pkg::OP_POINT) begin
          state_d = S_LMUL;
          ax_d    = 2'd0;
        end
      end
      S_LMUL: state_d = S_LCHK;
      S_LCHK: begin
        if (axis_oob) begin
          state_d = S_OUT;
        end else if (ax_q == 2'd2) begin
          state_d = S_FLAT;
        end else begin
          ax_d    = ax_q + 2'd1;
          state_d = S_LMUL;
        end
      end
      S_FLAT: begin
        step_d = 3'd0;
        fc_d   = 4'd0;
        if (cache_valid_q && cached_cell_q == flat) state_d = S_IMUL;
        else state_d = S_FETCH;
      end
      S_FETCH: begin
        fc_d = fc_q + 4'd1;
        if (fc_q == FETCH_LAST) state_d = S_IMUL;
      end
      S_IMUL: state_d = S_IADD;
      S_IADD: begin
        step_d = step_q + 3'd1;
        if (step_q == STEP_LAST) state_d = S_OUT;
        else state_d = S_IMUL;
      end
      S_OUT: begin
        if (out_fire) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      ax_q          <= 2'd0;
      fc_q          <= 4'd0;
      step_q        <= 3'd0;
      cache_valid_q <= 1'b0;
      cached_cell_q <= '0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      fc_q    <= fc_d;
      step_q  <= step_d;
      if (in_fire && (opcode_i == tgi_pkg::OP_WR_INDEX || opcode_i == tgi_pkg::OP_WR_VALUE)) begin
        cache_valid_q <= 1'b0;
      end else if (state_q == S_FETCH && fc_q == FETCH_LAST) begin
        cache_valid_q <= 1'b1;
        cached_cell_q <= flat_q;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_q[0] <= 32'd0;
      origin_q[1] <= 32'd0;
      origin_q[2] <= 32'd0;
      scale_q[0]  <= 32'h0001_0000;
      scale_q[1]  <= 32'h0001_0000;
      scale_q[2]  <= 32'h0001_0000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tgi_pkg::REG_X_ORIGIN: origin_q[0] <= cfg_wdata_i;
        tgi_pkg::REG_Y_ORIGIN: origin_q[1] <= cfg_wdata_i;
        tgi_pkg::REG_Z_ORIGIN: origin_q[2] <= cfg_wdata_i;
        tgi_pkg::REG_X_SCALE:  scale_q[0]  <= cfg_wdata_i;
        tgi_pkg::REG_Y_SCALE:  scale_q[1]  <= cfg_wdata_i;
        tgi_pkg::REG_Z_SCALE:  scale_q[2]  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // cached corners reset to zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 8; k++) corner_q[k] <= 32'd0;
    end else if (state_q == S_FETCH && fc_q >= 4'd2) begin
      corner_q[3'(fc_q - 4'd2)] <= slot_ok_q ? val_rdata : 32'd0;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      coord_q[0] <= x_coord_i;
      coord_q[1] <= y_coord_i;
      coord_q[2] <= z_coord_i;
    end
    if (state_q == S_LCHK) begin
      if (axis_zero) begin
        cell_q[ax_q] <= '0;
        wgt_q[ax_q]  <= '0;
      end else begin
        cell_q[ax_q] <= tgi_pkg::CELL_W'(mul_p[63:32]);
        wgt_q[ax_q]  <= mul_p[31:16];
      end
    end
    if (state_q == S_FLAT) flat_q <= flat;
    slot_ok_q <= 32'(idx_rdata) < 32'(tgi_pkg::VALUE_DEPTH);
    if (state_q == S_IADD && step_q != STEP_LAST) lr_q[step_q] <= lerp_r;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_LCHK && axis_oob) begin
      result_q <= 32'd0;
      oob_q    <= 1'b1;
    end else if (state_q == S_IADD && step_q == STEP_LAST) begin
      result_q <= lerp_r;
      oob_q    <= 1'b0;
    end
  end

  // checks
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_bounds_o |-> interpolated_o == 32'd0)
    else $error("out-of-bounds result not zero");

  a_write_clears_cache: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (opcode_i == tgi_pkg::OP_WR_INDEX || opcode_i == tgi_pkg::OP_WR_VALUE)
    |=> !cache_valid_q)
    else $error("table write left cache valid");

  a_fetch_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |-> fc_q <= FETCH_LAST)
    else $error("fetch counter overran");

  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("ready while result pending");

endmodule
